// ===== src/double_float_remainder_unit_assert.svh =====
// Assertion macros for the remainder unit checker.
`ifndef DOUBLE_FLOAT_REMAINDER_UNIT_ASSERT_SVH
`define DOUBLE_FLOAT_REMAINDER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define DFR_ASSERT(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DFR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dfr_pkg;

    typedef struct packed {
        logic [63:0] dividend_bits;
        logic [63:0] divisor_bits;
    } dfr_req_t;

    typedef struct packed {
        logic [63:0] remainder_bits;
        logic        domain_error;
    } dfr_rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;    // capture operands, classify
        logic norm;    // normalize subnormal significands one bit
        logic step;    // one shift-subtract step
        logic fin;     // final subtract
        logic renorm;  // result normalization one bit
        logic pack;    // form result
    } dfr_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic special;   // result decided by classification
        logic norm_done; // both significands have the hidden bit
        logic exp_eq;    // exponents equal
        logic rem_zero;  // running remainder is zero
        logic rem_norm;  // remainder has hidden bit
    } dfr_sts_t;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [51:0] FRAC_ZERO = 52'd0;
    localparam logic [10:0] EXP_ALL   = 11'h7FF;

endpackage
`default_nettype wire

// ===== src/double_float_remainder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Special operands go from classify straight to the result; others pass through
//   normalize, the shift-subtract loop, result renormalize and pack.
// Throughput: one request at a time; start is taken when busy is low.
// Result shows for one cycle with valid high; the receiver cannot stall.
// Reset (rst_n low, async) returns the controller to idle; no result pending.
module double_float_remainder_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  dfr_pkg::dfr_req_t      req,
    output logic                   valid,
    output dfr_pkg::dfr_rsp_t      rsp
);
    import dfr_pkg::*;

    // Controller sequences classify, normalize, shift-subtract, renormalize
    // and pack; datapath holds operands, significands and exponents.
    dfr_cmd_t cmd;
    dfr_sts_t sts;

    dfr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (valid),
        .sts   (sts),
        .cmd   (cmd)
    );

    dfr_datapath u_dp (
        .clk (clk),
        .req (req),
        .cmd (cmd),
        .sts (sts),
        .rsp (rsp)
    );
endmodule
`default_nettype wire

// ===== src/dfr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dfr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    input  dfr_pkg::dfr_sts_t      sts,
    output dfr_pkg::dfr_cmd_t      cmd
);
    import dfr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLASS  = 3'd1;
    localparam logic [2:0] S_NORM   = 3'd2;
    localparam logic [2:0] S_LOOP   = 3'd3;
    localparam logic [2:0] S_RENORM = 3'd4;
    localparam logic [2:0] S_PACK   = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != S_IDLE);
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (sts.special)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (sts.norm_done)
                begin
                    state_next = S_LOOP;
                end
                else
                begin
                    cmd.norm = 1'b1;
                end
            end
            S_LOOP:
            begin
                if (sts.exp_eq)
                begin
                    cmd.fin = 1'b1;
                    state_next = S_RENORM;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_RENORM:
            begin
                if (sts.rem_zero || sts.rem_norm)
                begin
                    state_next = S_PACK;
                end
                else
                begin
                    cmd.renorm = 1'b1;
                end
            end
            S_PACK:
            begin
                cmd.pack = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== src/dfr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dfr_datapath (
    input  wire logic              clk,
    input  dfr_pkg::dfr_req_t      req,
    input  dfr_pkg::dfr_cmd_t      cmd,
    output dfr_pkg::dfr_sts_t      sts,
    output dfr_pkg::dfr_rsp_t      rsp
);
    import dfr_pkg::*;

    // Exponents kept signed, 13 bits covers -103..2046.
    // Running remainder is one bit wider: shifted value reaches 2 * divisor.
    logic [63:0]        x_reg;
    logic [53:0]        mx_reg;
    logic [52:0]        my_reg;
    logic signed [12:0] ex_reg, ey_reg;
    logic               special_reg;
    dfr_rsp_t           rsp_reg;

    logic [10:0] xe, ye;
    logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero, x_lt;
    logic [54:0] diff;
    logic        ge;
    logic [53:0] sub_m;
    logic [11:0] rsh;
    logic [53:0] sub_out;

    assign xe     = req.dividend_bits[62:52];
    assign ye     = req.divisor_bits[62:52];
    assign x_nan  = (xe == EXP_ALL) && (req.dividend_bits[51:0] != FRAC_ZERO);
    assign y_nan  = (ye == EXP_ALL) && (req.divisor_bits[51:0] != FRAC_ZERO);
    assign x_inf  = (xe == EXP_ALL) && (req.dividend_bits[51:0] == FRAC_ZERO);
    assign y_inf  = (ye == EXP_ALL) && (req.divisor_bits[51:0] == FRAC_ZERO);
    assign x_zero = (req.dividend_bits[62:0] == 63'd0);
    assign y_zero = (req.divisor_bits[62:0] == 63'd0);
    assign x_lt   = (req.dividend_bits[62:0] < req.divisor_bits[62:0]);

    assign diff  = {1'b0, mx_reg} - {2'b00, my_reg};
    assign ge    = !diff[54];
    assign sub_m = ge ? diff[53:0] : mx_reg;

    // Subnormal result shift amount: 1 - ey.
    assign rsh     = 12'(13'sd1 - ey_reg);
    assign sub_out = mx_reg >> rsh;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= req.dividend_bits;
            mx_reg <= {1'b0, (xe != 11'd0), req.dividend_bits[51:0]};
            my_reg <= {(ye != 11'd0), req.divisor_bits[51:0]};
            ex_reg <= (xe == 11'd0) ? 13'sd1 : $signed({2'b00, xe});
            ey_reg <= (ye == 11'd0) ? 13'sd1 : $signed({2'b00, ye});
            special_reg <= 1'b1;
            if (x_nan)
            begin
                rsp_reg <= '{remainder_bits: req.dividend_bits, domain_error: 1'b1};
            end
            else if (y_nan)
            begin
                rsp_reg <= '{remainder_bits: req.divisor_bits, domain_error: 1'b1};
            end
            else if (x_inf || y_zero)
            begin
                rsp_reg <= '{remainder_bits: QNAN_BITS, domain_error: 1'b1};
            end
            else if (x_zero || y_inf || x_lt)
            begin
                rsp_reg <= '{remainder_bits: req.dividend_bits, domain_error: 1'b0};
            end
            else
            begin
                special_reg <= 1'b0;
                rsp_reg <= '{remainder_bits: 64'd0, domain_error: 1'b0};
            end
        end
        else if (cmd.norm)
        begin
            if (!mx_reg[52])
            begin
                mx_reg <= mx_reg << 1;
                ex_reg <= ex_reg - 13'sd1;
            end
            if (!my_reg[52])
            begin
                my_reg <= my_reg << 1;
                ey_reg <= ey_reg - 13'sd1;
            end
        end
        else if (cmd.step)
        begin
            // Zero remainder stays zero through further steps.
            mx_reg <= {sub_m[52:0], 1'b0};
            ex_reg <= ex_reg - 13'sd1;
        end
        else if (cmd.fin)
        begin
            mx_reg <= sub_m;
        end
        else if (cmd.renorm)
        begin
            mx_reg <= mx_reg << 1;
            ey_reg <= ey_reg - 13'sd1;
        end
        else if (cmd.pack)
        begin
            if (mx_reg == 54'd0)
            begin
                rsp_reg.remainder_bits <= {x_reg[63], 63'd0};
            end
            else if (ey_reg >= 13'sd1)
            begin
                rsp_reg.remainder_bits <= {x_reg[63], ey_reg[10:0], mx_reg[51:0]};
            end
            else
            begin
                rsp_reg.remainder_bits <= {x_reg[63], 10'd0, sub_out[52:0]};
            end
        end
    end

    assign sts.special   = special_reg;
    assign sts.norm_done = mx_reg[52] && my_reg[52];
    assign sts.exp_eq    = (ex_reg == ey_reg);
    assign sts.rem_zero  = (mx_reg == 54'd0);
    assign sts.rem_norm  = mx_reg[52];
    assign rsp = rsp_reg;
endmodule
`default_nettype wire

// ===== src/double_float_remainder_unit_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "double_float_remainder_unit_assert.svh"
module double_float_remainder_unit_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              valid,
    input dfr_pkg::dfr_rsp_t      rsp
);
    import dfr_pkg::*;

    // An accepted request makes the unit busy.
    `DFR_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "request not taken")
    // A result marks the end of the request.
    `DFR_ASSERT_NEXT(a_valid_idle, clk, rst_n, valid, !busy, "busy after result")
    // Results only appear while busy.
    `DFR_ASSERT(a_valid_busy, clk, rst_n, !valid || busy, "result while idle")
    // A result equal to the default quiet NaN always flags the error.
    `DFR_ASSERT(a_qnan_err, clk, rst_n,
        !(valid && rsp.remainder_bits == QNAN_BITS) || rsp.domain_error,
        "default NaN without error flag")
endmodule

bind double_float_remainder_unit double_float_remainder_unit_checker u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .valid (valid),
    .rsp   (rsp)
);
`default_nettype wire

// ===== tb/dfr_checker.sv =====
`timescale 1ns / 1ps
module dfr_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  dfr_pkg::dfr_req_t req,
    input  logic              valid,
    input  dfr_pkg::dfr_rsp_t rsp,
    output int                fail_count,
    output int                pending
);
    import dfr_pkg::*;

    dfr_rsp_t expected_q[$];
    int       seen;

    function automatic logic is_nan64(logic [63:0] b);
        return b[62:52] == EXP_ALL && b[51:0] != FRAC_ZERO;
    endfunction

    // Nonzero finite magnitude -> significand with hidden bit, exponent.
    function automatic void split(input logic [63:0] b, output logic [63:0] m,
                                  output int e);
        m = {12'd0, b[51:0]};
        e = b[62:52];
        if (e == 0)
        begin
            e = 1;
            while (!m[52])
            begin
                m = m << 1;
                e--;
            end
        end
        else
            m[52] = 1'b1;
    endfunction

    function automatic logic [63:0] fmod_bits(input logic [63:0] x,
                                              input logic [63:0] y);
        logic [63:0] sgn, mx, my;
        int ex, ey;
        sgn = {x[63], 63'd0};
        if (x[62:0] < y[62:0])
            return x;
        split(x & 64'h7FFF_FFFF_FFFF_FFFF, mx, ex);
        split(y & 64'h7FFF_FFFF_FFFF_FFFF, my, ey);
        while (ex > ey)
        begin
            if (mx >= my) mx -= my;
            if (mx == 0)
                return sgn;
            mx = mx << 1;
            ex--;
        end
        if (mx >= my) mx -= my;
        if (mx == 0)
            return sgn;
        while (!mx[52])
        begin
            mx = mx << 1;
            ey--;
        end
        if (ey >= 1)
            return sgn | (64'(ey) << 52) | {12'd0, mx[51:0]};
        return sgn | (mx >> (1 - ey));
    endfunction

    function automatic dfr_rsp_t predict(dfr_req_t q);
        dfr_rsp_t p;
        logic [63:0] x, y;
        x = q.dividend_bits;
        y = q.divisor_bits;
        p.domain_error = 1'b1;
        if (is_nan64(x))
            p.remainder_bits = x;
        else if (is_nan64(y))
            p.remainder_bits = y;
        else if (x[62:0] == {EXP_ALL, FRAC_ZERO} || y[62:0] == 63'd0)
            p.remainder_bits = QNAN_BITS;
        else
        begin
            p.domain_error = 1'b0;
            if (x[62:0] == 63'd0 || y[62:0] == {EXP_ALL, FRAC_ZERO})
                p.remainder_bits = x;
            else
                p.remainder_bits = fmod_bits(x, y);
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH t=%0t %s got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        seen = 0;
    end

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        dfr_rsp_t want;
        if (rst_n)
        begin
            if (valid)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result", rsp.remainder_bits, 64'd0);
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.remainder_bits !== want.remainder_bits)
                        report_mismatch("remainder_bits", rsp.remainder_bits,
                                        want.remainder_bits);
                    if (rsp.domain_error !== want.domain_error)
                        report_mismatch("domain_error", 64'(rsp.domain_error),
                                        64'(want.domain_error));
                end
                seen++;
            end
            if (start && !busy)
                expected_q.push_back(predict(req));
        end
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the binary64 remainder unit. Requests mix
// directed special operands (NaN, inf, zero, subnormal, extreme exponents)
// with random patterns biased toward close exponents so most requests
// exercise the shift-subtract loop; a few take the widest exponent spread.
module tb;
    import dfr_pkg::*;

    localparam int N_RANDOM    = 260;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN       = 2300;  // worst-case latency after last result

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    logic     valid;
    dfr_req_t req = '0;
    dfr_rsp_t rsp;
    int       fail_count;
    int       pending;
    int       cycles = 0;
    int       n_sent = 0;
    logic     no_idle = 1'b0;

    always #10 clk = ~clk;

    double_float_remainder_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .valid(valid), .rsp(rsp)
    );

    dfr_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .valid(valid), .rsp(rsp), .fail_count(fail_count), .pending(pending)
    );

    // Watchdog: fails the run if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random finite operand with exponent in [lo, hi]; sign and fraction random.
    function automatic logic [63:0] rand_num(int lo, int hi);
        logic [63:0] v;
        v = rand64();
        v[62:52] = 11'($urandom_range(hi, lo));
        return v;
    endfunction

    // Hands one request over; idles first at random unless in the no-idle stretch.
    task automatic send(input logic [63:0] x, input logic [63:0] y);
        while (!no_idle && $urandom_range(99) < 15)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= '{dividend_bits: x, divisor_bits: y};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_sent++;
    endtask

    initial
    begin
        int e;
        int kind;
        logic [63:0] a, b;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: special cases in priority order, extremes, subnormals.
        send(64'h7FF0_0000_0000_0001, 64'h0000_0000_0000_0000); // sNaN x
        send(64'hFFF8_0000_0000_0000, 64'h7FF8_0000_0000_0001); // NaN both
        send(64'h3FF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF); // NaN y
        send(64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000); // inf x
        send(64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000); // inf/inf
        send(64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000); // 0/0
        send(64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000); // zero y
        send(64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000); // zero x
        send(64'hC008_0000_0000_0000, 64'hFFF0_0000_0000_0000); // inf y
        send(64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000); // |x|<|y|
        send(64'hC010_0000_0000_0000, 64'h4000_0000_0000_0000); // exact zero, neg
        send(64'h4014_0000_0000_0000, 64'h4000_0000_0000_0000); // 5 mod 2
        send(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001); // widest spread
        send(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0003);
        send(64'h0000_0000_0000_0007, 64'h0000_0000_0000_0002); // subnormals
        send(64'h800F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0003);
        send(64'h0010_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF); // subnormal result
        send(64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000);
        send(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFE);
        send(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send(64'h4340_0000_0000_0000, 64'h3FB9_9999_9999_999A);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            no_idle = (i >= 100 && i < 150);
            kind = $urandom_range(99);
            if (kind < 65)
            begin
                // close exponents: short loops, many renormalizations
                e = $urandom_range(2046, 1);
                a = rand_num(e, e);
                b = rand_num((e > 60) ? e - 60 : 1, e);
            end
            else if (kind < 80)
            begin
                // subnormals mixed with small normals
                a = rand_num(0, 60);
                b = rand_num(0, 3);
            end
            else if (kind < 83)
            begin
                a = rand_num(1500, 2046);
                b = rand_num(0, 200);
            end
            else if (kind < 93)
            begin
                a = rand64();
                b = rand64();
                if (a[62:52] > b[62:52] + 11'd80)
                    a[62:52] = b[62:52] + 11'($urandom_range(80));
            end
            else
            begin
                // special operands at random
                a = rand64();
                b = rand64();
                case ($urandom_range(3))
                    0: a[62:52] = EXP_ALL;
                    1: b[62:52] = EXP_ALL;
                    2: b[62:0] = 63'd0;
                    default: a[62:0] = 63'd0;
                endcase
            end
            send(a, b);
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d requests: special operands, subnormals, exact zeros,", n_sent);
        $display("close and far exponent spreads with random handshake gaps.");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== double_float_remainder_unit.f =====
+incdir+src
src/dfr_pkg.sv
src/dfr_ctrl.sv
src/dfr_datapath.sv
src/double_float_remainder_unit.sv
src/double_float_remainder_unit_checker.sv
tb/dfr_checker.sv
tb/tb.sv
